### rtl/ctt_pkg.sv
// Shared types and constants of the connection tracking table.
`timescale 1ns / 1ps
package ctt_pkg;

	localparam logic [1:0] OP_TRACK  = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [7:0] PROTO_ICMP  = 8'd1;
	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_ICMP6 = 8'd58;

	localparam logic [5:0] FLAG_MASK = 6'h3F;
	localparam logic [5:0] FL_ACK = 6'h10;
	localparam logic [5:0] FL_RST = 6'h04;
	localparam logic [5:0] FL_SYN = 6'h02;
	localparam logic [5:0] FL_FIN = 6'h01;
	localparam logic [7:0] ICMP_ECHO_REQ = 8'h80;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_NEW  = 2'd1;
	localparam logic [1:0] ST_EST  = 2'd2;

	localparam logic [1:0] REG_LOCAL_HIGH = 2'd0;
	localparam logic [1:0] REG_LOCAL_LOW  = 2'd1;
	localparam logic [1:0] REG_NEW_TMO    = 2'd2;
	localparam logic [1:0] REG_SWEEP_INT  = 2'd3;

	// One table entry.
	typedef struct packed {
		logic [63:0] sh;
		logic [63:0] sl;
		logic [63:0] dh;
		logic [63:0] dl;
		logic [7:0]  pr;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [1:0]  st;
		logic [31:0] stamp;
	} entry_t;

	// Classified command from the front end to the table engine.
	typedef struct packed {
		logic        is_lookup;
		logic        is_track;
		logic        is_tick;
		logic        do_add;
		logic        est_rev;
		logic        est_fwd;
		logic        del_fwd;
		logic        del_rev;
		logic [63:0] sh;
		logic [63:0] sl;
		logic [63:0] dh;
		logic [63:0] dl;
		logic [7:0]  pr;
		logic [15:0] sp;
		logic [15:0] dp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] conn_state;
		logic [6:0] entries_in_use;
		logic       insert_dropped;
	} res_t;

endpackage

### rtl/connection_tracking_table_top.sv
// Top level of the IPv6 connection tracking table.
`timescale 1ns / 1ps
// Tracks up to TABLE_ENTRIES five-tuple connections in insertion order. Items
// are taken on s_axis and decoded into a two-entry command queue; the table
// engine carries out one command at a time against a one-read, one-write entry
// memory and returns one result beat on m_axis per item. A lookup or a track
// item walks the table entry by entry in each scan (a track item may scan up to
// four times, plus a sweep), and each removal shifts the later entries down one
// by one. The user must write configuration only while the block is idle; the
// block itself does not enforce this.
module connection_tracking_table_top import ctt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op, from_outside, protocol, src_addr_high, src_addr_low, dst_addr_high,
	// dst_addr_low, src_port, dst_port, tcp_flags, icmp_type (low bit up)
	input  logic [319:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// conn_state, entries_in_use, insert_dropped (low bit up)
	output logic [15:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0] local_high_q, local_low_q;
	logic [15:0] new_tmo_q, sweep_int_q;
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_high_q <= '0;
			local_low_q  <= '0;
			new_tmo_q    <= 16'd60;
			sweep_int_q  <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCAL_HIGH: local_high_q <= cfg_data;
				REG_LOCAL_LOW:  local_low_q  <= cfg_data;
				REG_NEW_TMO:    new_tmo_q    <= cfg_data[15:0];
				REG_SWEEP_INT:  sweep_int_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ctt_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[1:0]), .from_outside(s_axis_tdata[2]),
		.protocol(s_axis_tdata[10:3]),
		.src_addr_high(s_axis_tdata[74:11]), .src_addr_low(s_axis_tdata[138:75]),
		.dst_addr_high(s_axis_tdata[202:139]), .dst_addr_low(s_axis_tdata[266:203]),
		.src_port(s_axis_tdata[282:267]), .dst_port(s_axis_tdata[298:283]),
		.tcp_flags(s_axis_tdata[304:299]), .icmp_type(s_axis_tdata[312:305]),
		.local_high(local_high_q), .local_low(local_low_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	ctt_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.new_timeout(new_tmo_q), .sweep_interval(sweep_int_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {6'd0, res.insert_dropped, res.entries_in_use, res.conn_state};

endmodule

### rtl/ctt_front.sv
// Front end: accepts input beats, decodes them into table commands.
`timescale 1ns / 1ps
module ctt_front import ctt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   op,
	input  logic         from_outside,
	input  logic [7:0]   protocol,
	input  logic [63:0]  src_addr_high,
	input  logic [63:0]  src_addr_low,
	input  logic [63:0]  dst_addr_high,
	input  logic [63:0]  dst_addr_low,
	input  logic [15:0]  src_port,
	input  logic [15:0]  dst_port,
	input  logic [5:0]   tcp_flags,
	input  logic [7:0]   icmp_type,
	input  logic [63:0]  local_high,
	input  logic [63:0]  local_low,
	output logic         cmd_valid,
	input  logic         cmd_ready,
	output cmd_t         cmd
);

	// Two-deep queue toward the engine.
	cmd_t       q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic [5:0] fl;
	logic       syn, ack, mine, icmp, push, pop;

	always_comb begin
		fl   = tcp_flags & FLAG_MASK;
		syn  = (fl & FL_SYN) != 6'd0;
		ack  = (fl & FL_ACK) != 6'd0;
		mine = (src_addr_high == local_high) && (src_addr_low == local_low);
		icmp = (protocol == PROTO_ICMP) || (protocol == PROTO_ICMP6);
		c = '0;
		c.is_lookup = (op == OP_LOOKUP);
		c.is_track  = (op == OP_TRACK);
		c.is_tick   = (op == OP_TICK);
		c.sh = src_addr_high;
		c.sl = src_addr_low;
		c.dh = dst_addr_high;
		c.dl = dst_addr_low;
		c.pr = protocol;
		c.sp = icmp && (op == OP_TRACK) ? 16'd0 : src_port;
		c.dp = icmp && (op == OP_TRACK) ? 16'd0 : dst_port;
		if (op == OP_TRACK) begin
			if (protocol == PROTO_TCP) begin
				c.do_add  = syn && from_outside;
				c.est_rev = syn && ack && !from_outside;
				c.est_fwd = syn && ack && from_outside;
				c.del_fwd = ((fl & FL_FIN) != 6'd0) && from_outside;
				c.del_rev = ((fl & FL_RST) != 6'd0) && !from_outside;
			end else if (protocol == PROTO_UDP) begin
				c.do_add  = (from_outside == !mine);
				c.del_rev = !(from_outside == !mine);
			end else if (icmp) begin
				c.do_add  = (icmp_type == ICMP_ECHO_REQ);
				c.del_rev = (icmp_type != ICMP_ECHO_REQ);
			end
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### rtl/ctt_engine.sv
// Table engine: walks the entry memory to carry out one command at a time.
`timescale 1ns / 1ps
module ctt_engine import ctt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [15:0] new_timeout,
	input  logic [15:0] sweep_interval,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_WR, S_ADD, S_SHRD, S_SHWR, S_SWCHK, S_DONE
	} state_t;

	// Scan purposes in command order.
	typedef enum logic [2:0] {
		P_ADD, P_EST, P_DEL1, P_DEL2, P_LOOK, P_SWEEP
	} phase_t;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;
	entry_t wr_data;
	logic   wr_en;
	logic [AW-1:0] wr_addr, rd_addr;

	state_t        state_q;
	phase_t        phase_q;
	cmd_t          c_q;
	logic [CW-1:0] total_q, idx_q, hit_q, sh_q;
	logic [31:0]   now_q, last_q;
	logic          dropped_q;
	logic [1:0]    st_q;
	phase_t        ret_q;

	logic fwd_m, rev_m, key_m, tcp_learn, port_rev, stale, sweep_due;
	logic [CW-1:0] idx_nx;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		fwd_m = rd_q.sh == c_q.sh && rd_q.sl == c_q.sl && rd_q.dh == c_q.dh &&
			rd_q.dl == c_q.dl && rd_q.pr == c_q.pr && rd_q.sp == c_q.sp &&
			rd_q.dp == c_q.dp;
		key_m = rd_q.sh == c_q.dh && rd_q.sl == c_q.dl && rd_q.dh == c_q.sh &&
			rd_q.dl == c_q.sl && rd_q.pr == c_q.pr;
		port_rev  = rd_q.sp == c_q.dp && rd_q.dp == c_q.sp;
		rev_m     = key_m && port_rev;
		tcp_learn = rd_q.pr == PROTO_TCP && rd_q.sp == 16'd0 && rd_q.dp == c_q.dp;
		stale = rd_q.st == ST_NEW &&
			{1'b0, now_q} > ({1'b0, rd_q.stamp} + 33'(new_timeout));
		sweep_due = {1'b0, now_q} > ({1'b0, last_q} + 33'(sweep_interval));
		idx_nx = idx_q + 1'b1;
	end

	// Memory port steering.
	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (state_q)
			S_SHRD: rd_addr = sh_q[AW-1:0] + 1'b1;
			S_WR: begin
				wr_en   = 1'b1;
				wr_addr = hit_q[AW-1:0];
				wr_data = rd_q;
				if (phase_q == P_EST) wr_data.st = ST_EST;
				else wr_data.sp = c_q.sp;
			end
			S_ADD: begin
				wr_en   = 1'b1;
				wr_addr = total_q[AW-1:0];
				wr_data = {c_q.sh, c_q.sl, c_q.dh, c_q.dl, c_q.pr, c_q.sp, c_q.dp,
					ST_NEW, now_q};
			end
			S_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = sh_q[AW-1:0];
				wr_data = rd_q;
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE) && !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_ADD;
			ret_q       <= P_ADD;
			total_q     <= '0;
			now_q       <= '0;
			last_q      <= '0;
			idx_q       <= '0;
			hit_q       <= '0;
			sh_q        <= '0;
			dropped_q   <= 1'b0;
			st_q        <= ST_NONE;
			res_valid   <= 1'b0;
			res         <= '0;
			c_q         <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						c_q         <= cmd;
						idx_q       <= '0;
						dropped_q   <= 1'b0;
						st_q        <= ST_NONE;
						if (cmd.is_tick) begin
							now_q   <= now_q + 32'd1;
							state_q <= S_DONE;
						end else if (cmd.is_lookup) begin
							phase_q <= P_LOOK;
							state_q <= S_RD;
						end else if (cmd.is_track) begin
							phase_q <= P_ADD;
							state_q <= S_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				// Wait for registered read, or step past the phase when done.
				S_RD: begin
					if (idx_q >= total_q || !(
						(phase_q == P_ADD && c_q.do_add) ||
						(phase_q == P_EST && (c_q.est_rev || c_q.est_fwd)) ||
						(phase_q == P_DEL1 && c_q.del_fwd) ||
						(phase_q == P_DEL2 && c_q.del_rev) ||
						phase_q == P_LOOK || phase_q == P_SWEEP)) begin
						idx_q <= '0;
						case (phase_q)
							P_ADD: begin
								if (c_q.do_add) begin
									if (total_q >= FULL) dropped_q <= 1'b1;
									else state_q <= S_ADD;
								end
								phase_q <= P_EST;
							end
							P_EST:  phase_q <= P_DEL1;
							P_DEL1: phase_q <= P_DEL2;
							P_DEL2: begin
								phase_q <= P_SWEEP;
								if (!sweep_due) state_q <= S_DONE;
							end
							P_LOOK: state_q <= S_DONE;
							default: begin
								last_q  <= now_q;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= S_RD;
					idx_q   <= idx_nx;
					case (phase_q)
						P_ADD: if (fwd_m) begin
							phase_q <= P_EST;
							idx_q   <= '0;
						end
						P_EST: if (c_q.est_rev ? rev_m : fwd_m) begin
							hit_q   <= idx_q;
							state_q <= S_WR;
						end
						P_DEL1, P_DEL2: if (phase_q == P_DEL1 ? fwd_m : rev_m) begin
							sh_q    <= idx_q;
							ret_q   <= phase_q;
							state_q <= S_SHRD;
						end
						P_LOOK: begin
							if (key_m) begin
								if (c_q.pr == PROTO_ICMP6) begin
									// keep the last matching entry
									st_q <= rd_q.st;
								end else if (tcp_learn) begin
									st_q    <= rd_q.st;
									hit_q   <= idx_q;
									state_q <= S_WR;
								end else if (port_rev) begin
									st_q    <= rd_q.st;
									state_q <= S_DONE;
								end
							end
						end
						default: if (stale) begin
							sh_q    <= idx_q;
							ret_q   <= P_SWEEP;
							idx_q   <= idx_q;
							state_q <= S_SHRD;
						end
					endcase
				end
				S_WR: begin
					state_q <= (phase_q == P_LOOK) ? S_DONE : S_RD;
					if (phase_q == P_EST) begin
						phase_q <= P_DEL1;
						idx_q   <= '0;
					end
				end
				S_ADD: begin
					total_q <= total_q + 1'b1;
					state_q <= S_RD;
				end
				// Shift entries down over the removed one, one entry at a time.
				S_SHRD: begin
					if (sh_q + 1'b1 >= total_q) begin
						total_q <= total_q - 1'b1;
						state_q <= S_RD;
						if (ret_q != P_SWEEP) begin
							phase_q <= (ret_q == P_DEL1) ? P_DEL2 : P_SWEEP;
							idx_q   <= '0;
							if (ret_q == P_DEL2 && !sweep_due) state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					sh_q    <= sh_q + 1'b1;
					state_q <= S_SHRD;
				end
				S_DONE: begin
					if (!res_valid || res_ready) begin
						res_valid <= 1'b1;
						res.conn_state     <= c_q.is_lookup ? st_q : ST_NONE;
						res.entries_in_use <= 7'(total_q);
						res.insert_dropped <= dropped_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
